// ===== hw/rtl/rational_arith_reduce_macros.svh =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_macros.svh
// Assertion macros shared by the checker of the rational arithmetic block.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define RAR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rar check failed");

// next-cycle implication
`define RAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rar check failed");

`endif

// ===== hw/rtl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg
// Types, codes and defaults of the rational arithmetic block.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDTH_DEF = 32;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] KIND_FINITE = 2'd0;
    localparam logic [1:0] KIND_INF    = 2'd1;
    localparam logic [1:0] KIND_NAN    = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [FIELD_W-1:0]  a_num;
        logic signed [FIELD_W-1:0]  a_den;
        logic signed [FIELD_W-1:0]  b_num;
        logic signed [FIELD_W-1:0]  b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  res_num;
        logic signed [FIELD_W-1:0]  res_den;
        logic [1:0]                 kind;
        logic                       is_integer;
        logic                       overflow;
    } out_item_t;

    // control flags of one queued job
    typedef struct packed {
        logic num_neg;
        logic den_neg;
        logic reduce;
    } job_flags_t;

endpackage

// ===== hw/rtl/rar_queue.sv =====
// ----------------------------------------------------------------------------
// rar_queue
// Short FIFO between the front and the back of the block.
// ----------------------------------------------------------------------------
module rar_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = rar_pkg::QDEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wp_reg, rp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

// ===== hw/rtl/rar_front.sv =====
// ----------------------------------------------------------------------------
// rar_front
// Accepts a beat, forms the cross products on one shared multiplier,
// combines them and classifies the pair before queuing it.
// ----------------------------------------------------------------------------
module rar_front #(
    parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rar_pkg::in_item_t    item,
    output logic                 full,
    output logic                 job_wr,
    output rar_pkg::job_flags_t  job_flags,
    output logic [2*WIDTH-1:0]   job_num,
    output logic [2*WIDTH-1:0]   job_den,
    input  logic                 job_full
);
    import rar_pkg::*;

    localparam int PW = 2 * WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_COMB = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [1:0]       op_reg;
    logic             an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [PW-1:0]    p_reg [3];
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [PW-1:0]    prod;
    job_flags_t       flags_reg;
    logic [PW-1:0]    num_reg, den_reg;
    logic             accept;

    // field to sign and magnitude
    function automatic logic [WIDTH-1:0] mag_of(input logic [FIELD_W-1:0] raw);
        logic [WIDTH-1:0] v;
        v = raw[WIDTH-1:0];
        return v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    assign full   = (state_reg != ST_IDLE);
    assign accept = push && !full;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        unique case (step_reg)
            2'd0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // combine products into numerator and denominator, then classify
    logic          s1_neg, s2_neg, sum_neg, dn_neg;
    logic [PW-1:0] sum_mag;
    job_flags_t    fl;
    logic [PW-1:0] nm, dm;
    logic          is_addsub;

    always_comb
    begin
        is_addsub = (op_reg == OP_ADD) || (op_reg == OP_SUB);
        s1_neg = (p_reg[0] != '0) &&
                 (an_s_reg ^ ((op_reg == OP_MUL) ? bn_s_reg : bd_s_reg));
        s2_neg = (p_reg[1] != '0) && (bn_s_reg ^ ad_s_reg ^ (op_reg == OP_SUB));
        dn_neg = (p_reg[2] != '0) &&
                 (ad_s_reg ^ ((op_reg == OP_DIV) ? bn_s_reg : bd_s_reg));
        if (!is_addsub)
        begin
            sum_mag = p_reg[0];
            sum_neg = s1_neg;
        end
        else if (s1_neg == s2_neg)
        begin
            sum_mag = p_reg[0] + p_reg[1];
            sum_neg = s1_neg;
        end
        else if (p_reg[0] >= p_reg[1])
        begin
            sum_mag = p_reg[0] - p_reg[1];
            sum_neg = s1_neg;
        end
        else
        begin
            sum_mag = p_reg[1] - p_reg[0];
            sum_neg = s2_neg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
        nm = sum_mag;
        dm = p_reg[2];
        fl.num_neg = sum_neg;
        fl.den_neg = dn_neg;
        fl.reduce  = 1'b0;
        priority if ((!sum_neg && nm == PW'(1)) || (!dn_neg && dm == PW'(1)))
        begin
            fl.reduce = 1'b0;
        end
        else if (nm == '0)
        begin
            // zero numerator: result is 0/1
            dm = PW'(1);
            fl.den_neg = 1'b0;
        end
        else if (dm != '0)
        begin
            fl.reduce = 1'b1;
        end
        else
        begin
            // zero denominator: left unreduced
            fl.reduce = 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                    step_next  = 2'd0;
                end
            end
            ST_MUL:
            begin
                if (step_reg == 2'd2)
                begin
                    state_next = ST_COMB;
                end
                step_next = step_reg + 1'b1;
            end
            ST_COMB:
            begin
                state_next = ST_PUSH;
            end
            default:
            begin
                if (!job_full)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item.opcode;
            an_s_reg <= item.a_num[WIDTH-1];
            ad_s_reg <= item.a_den[WIDTH-1];
            bn_s_reg <= item.b_num[WIDTH-1];
            bd_s_reg <= item.b_den[WIDTH-1];
            an_reg   <= mag_of(item.a_num);
            ad_reg   <= mag_of(item.a_den);
            bn_reg   <= mag_of(item.b_num);
            bd_reg   <= mag_of(item.b_den);
        end
        if (state_reg == ST_MUL)
        begin
            p_reg[step_reg] <= prod;
        end
        if (state_reg == ST_COMB)
        begin
            flags_reg <= fl;
            num_reg   <= nm;
            den_reg   <= dm;
        end
    end

    assign job_wr    = (state_reg == ST_PUSH) && !job_full;
    assign job_flags = flags_reg;
    assign job_num   = num_reg;
    assign job_den   = den_reg;
endmodule

// ===== hw/rtl/rar_back.sv =====
// ----------------------------------------------------------------------------
// rar_back
// Reduces a queued pair by a binary GCD and a shared restoring divider,
// then formats the result into the output register.
// ----------------------------------------------------------------------------
module rar_back #(
    parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_empty,
    input  rar_pkg::job_flags_t  job_flags,
    input  logic [2*WIDTH-1:0]   job_num,
    input  logic [2*WIDTH-1:0]   job_den,
    output logic                 job_rd,
    output rar_pkg::out_item_t   result,
    output logic                 empty,
    input  logic                 pop
);
    import rar_pkg::*;

    localparam int PW = 2 * WIDTH;
    localparam int KW = $clog2(PW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIVN = 3'd2;
    localparam logic [2:0] ST_DIVD = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic          nneg_reg, dneg_reg;
    logic [PW-1:0] nmag_reg, dmag_reg;
    logic [PW-1:0] x_reg, y_reg, g_reg;
    logic [KW-1:0] k_reg, cnt_reg;
    logic [PW-1:0] q_reg, rem_reg;
    logic          vld_reg;
    out_item_t     res_reg;

    logic          gcd_done, fin_go;
    logic [PW-1:0] g_val;
    logic [PW:0]   rem_sh;
    logic          sub_ok;

    assign gcd_done = (x_reg == '0) || (y_reg == '0);
    assign g_val    = (x_reg | y_reg) << k_reg;
    assign rem_sh   = {rem_reg, q_reg[PW-1]};
    assign sub_ok   = (rem_sh >= {1'b0, g_reg});
    assign fin_go   = (state_reg == ST_FIN) && (!vld_reg || pop);
    assign job_rd   = (state_reg == ST_IDLE) && !job_empty;

    // result formatting from the exact reduced pair
    logic [PW-1:0] nval, dval, half;
    out_item_t     fmt;
    always_comb
    begin
        half = PW'(1) << (WIDTH - 1);
        nval = nneg_reg ? (~nmag_reg + 1'b1) : nmag_reg;
        dval = dneg_reg ? (~dmag_reg + 1'b1) : dmag_reg;
        fmt.res_num = FIELD_W'($signed(nval[WIDTH-1:0]));
        fmt.res_den = FIELD_W'($signed(dval[WIDTH-1:0]));
        priority if (dmag_reg != '0)
        begin
            fmt.kind = KIND_FINITE;
        end
        else if (nmag_reg != '0)
        begin
            fmt.kind = KIND_INF;
        end
        else
        begin
            fmt.kind = KIND_NAN;
        end
        fmt.is_integer = (fmt.kind == KIND_FINITE) && !dneg_reg && (dmag_reg == PW'(1));
        fmt.overflow = !((nneg_reg ? (nmag_reg <= half) : (nmag_reg < half)) &&
                         (dneg_reg ? (dmag_reg <= half) : (dmag_reg < half)));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = job_flags.reduce ? ST_GCD : ST_FIN;
                end
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    state_next = (g_val == PW'(1)) ? ST_FIN : ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (cnt_reg == KW'(PW - 1))
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (cnt_reg == KW'(PW - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    // datapath: GCD steps, one divider bit per cycle
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                nneg_reg <= job_flags.num_neg;
                dneg_reg <= job_flags.den_neg;
                nmag_reg <= job_num;
                dmag_reg <= job_den;
                x_reg    <= job_num;
                y_reg    <= job_den;
                k_reg    <= '0;
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    g_reg   <= g_val;
                    q_reg   <= nmag_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_reg <= y_reg >> 1;
                end
                else if (x_reg >= y_reg)
                begin
                    x_reg <= (x_reg - y_reg) >> 1;
                end
                else
                begin
                    y_reg <= (y_reg - x_reg) >> 1;
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                rem_reg <= sub_ok ? PW'(rem_sh - {1'b0, g_reg}) : rem_sh[PW-1:0];
                q_reg   <= {q_reg[PW-2:0], sub_ok};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == KW'(PW - 1))
                begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    if (state_reg == ST_DIVN)
                    begin
                        nmag_reg <= {q_reg[PW-2:0], sub_ok};
                        q_reg    <= dmag_reg;
                    end
                    else
                    begin
                        dmag_reg <= {q_reg[PW-2:0], sub_ok};
                    end
                end
            end
            default:
            begin
                if (fin_go)
                begin
                    res_reg <= fmt;
                end
            end
        endcase
    end

    assign result = res_reg;
    assign empty  = !vld_reg;
endmodule

// ===== hw/rtl/rational_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by its greatest common divisor.
// ----------------------------------------------------------------------------
// One beat in gives one beat out, in order. The front takes a new beat only
// once it is idle again after the accept cycle, three products on one shared
// WIDTHxWIDTH multiplier, a combine step and a queue write, which waits while
// the queue is full. The back then runs a binary GCD over the 2*WIDTH-bit
// pair and, when the divisor exceeds one, a restoring divider of one bit per
// cycle divides both parts; pairs with a numerator or denominator of +1, or a
// zero part, skip both. A two-entry queue and the output register let the
// front accept new beats while a result waits to be popped.
module rational_arith_reduce #(
    parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rar_pkg::in_item_t   item,
    output logic                full,
    output rar_pkg::out_item_t  result,
    output logic                empty,
    input  logic                pop
);
    import rar_pkg::*;

    localparam int PW     = 2 * WIDTH;
    localparam int DATA_W = $bits(job_flags_t) + 2 * PW;

    logic              job_wr, job_rd, job_full, job_empty;
    job_flags_t        wr_flags, rd_flags;
    logic [PW-1:0]     wr_num, wr_den, rd_num, rd_den;
    logic [DATA_W-1:0] rd_data;

    rar_front #(.WIDTH(WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .job_wr    (job_wr),
        .job_flags (wr_flags),
        .job_num   (wr_num),
        .job_den   (wr_den),
        .job_full  (job_full)
    );

    rar_queue #(.DATA_W(DATA_W), .DEPTH(QDEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data ({wr_flags, wr_num, wr_den}),
        .q_full  (job_full),
        .rd_en   (job_rd),
        .rd_data (rd_data),
        .q_empty (job_empty)
    );

    assign {rd_flags, rd_num, rd_den} = rd_data;

    rar_back #(.WIDTH(WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_flags (rd_flags),
        .job_num   (rd_num),
        .job_den   (rd_den),
        .job_rd    (job_rd),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );
endmodule

// ===== hw/rtl/rar_checker.sv =====
// ----------------------------------------------------------------------------
// rar_checker
// Port-level checks of the rational arithmetic block, bound to its top level.
// ----------------------------------------------------------------------------
`include "rational_arith_reduce_macros.svh"

module rar_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input rar_pkg::in_item_t   item,
    input logic                full,
    input rar_pkg::out_item_t  result,
    input logic                empty,
    input logic                pop
);
    import rar_pkg::*;

    // a waiting result stays until popped
    `RAR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))

    // without overflow, finite exactly when the denominator is nonzero
    `RAR_ASSERT_NOW(a_kind, !empty && !result.overflow, (result.kind == KIND_FINITE) == (result.res_den != '0))

    // integer results carry a denominator of one
    `RAR_ASSERT_NOW(a_int, !empty && result.is_integer, (result.kind == KIND_FINITE) && (result.res_den == 1))

    // infinite results carry a zero denominator
    `RAR_ASSERT_NOW(a_inf, !empty && (result.kind == KIND_INF), result.res_den == '0)
endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);

// ===== test/rational_arith_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_tb
// Checks the rational add/sub/mul/div block with GCD reduction. A directed
// set of corner cases is followed by random beats. Both sides of the queue
// interface idle at random. Every popped beat is compared field by field
// against an in-order store of predicted results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arith_reduce_tb;

    import rar_pkg::*;

    localparam int W         = WIDTH_DEF;
    localparam int N_RANDOM  = 800;
    localparam int CYC_LIMIT = 3000000;
    localparam int DRAIN_CYC = 8 * W + 40;

    // sign and magnitude, wide enough for exact cross products
    typedef struct {
        bit          neg;
        bit [63:0]   mag;
    } smag_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    in_item_t   item;
    logic       full;
    out_item_t  result;
    logic       empty;
    logic       pop;

    in_item_t   pending_items[$];
    out_item_t  expected_results[$];
    int         err_cnt;
    int         cycle_cnt = 0;
    int         push_gap;
    int         pop_gap;
    bit         push_burst;
    bit         pop_burst;

    rational_arith_reduce #(.WIDTH(W)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    // ------------------------------------------------------------------
    // result predictor
    // ------------------------------------------------------------------
    function automatic smag_t field_to_smag(logic [31:0] raw);
        smag_t       r;
        logic [31:0] v;
        v     = raw[W-1:0];
        r.neg = v[W-1];
        r.mag = r.neg ? {32'd0, -v} : {32'd0, v};
        return r;
    endfunction

    function automatic smag_t smag_mul(smag_t x, smag_t y);
        smag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic smag_t smag_add(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end
        else if (x.mag >= y.mag)
        begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end
        else
        begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic bit smag_fits(smag_t v);
        bit [63:0] half;
        half = 64'd1 << (W - 1);
        return v.neg ? (v.mag <= half) : (v.mag < half);
    endfunction

    function automatic logic [31:0] smag_to_field(smag_t v);
        bit [63:0] t;
        t = v.neg ? (64'd0 - v.mag) : v.mag;
        return t[31:0];
    endfunction

    function automatic out_item_t predict_fraction(in_item_t it);
        out_item_t o;
        smag_t     an, ad, bn, bd, nu, de, t2;
        bit [63:0] x, y, t;
        an = field_to_smag(it.a_num);
        ad = field_to_smag(it.a_den);
        bn = field_to_smag(it.b_num);
        bd = field_to_smag(it.b_den);
        case (it.opcode)
            OP_ADD, OP_SUB:
            begin
                t2 = smag_mul(bn, ad);
                if (it.opcode == OP_SUB && t2.mag != 0)
                    t2.neg = !t2.neg;
                nu = smag_add(smag_mul(an, bd), t2);
                de = smag_mul(ad, bd);
            end
            OP_MUL:
            begin
                nu = smag_mul(an, bn);
                de = smag_mul(ad, bd);
            end
            default:
            begin
                nu = smag_mul(an, bd);
                de = smag_mul(ad, bn);
            end
        endcase
        // reduction, skipped when either part is exactly +1
        if (!(!nu.neg && nu.mag == 1) && !(!de.neg && de.mag == 1))
        begin
            if (nu.mag == 0)
            begin
                de.neg = 1'b0;
                de.mag = 1;
            end
            else if (de.mag != 0)
            begin
                x = nu.mag;
                y = de.mag;
                while (y != 0)
                begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                if (x > 1)
                begin
                    nu.mag = nu.mag / x;
                    de.mag = de.mag / x;
                end
            end
        end
        if (de.mag != 0)
            o.kind = KIND_FINITE;
        else if (nu.mag != 0)
            o.kind = KIND_INF;
        else
            o.kind = KIND_NAN;
        o.is_integer = (o.kind == KIND_FINITE) && !de.neg && de.mag == 1;
        o.res_num    = smag_to_field(nu);
        o.res_den    = smag_to_field(de);
        o.overflow   = !(smag_fits(nu) && smag_fits(de));
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_field();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 40) - 20;
            4:          v = ($urandom_range(1, 12) * $urandom_range(1, 500))
                            * ($urandom_range(0, 1) ? -1 : 1);
            5:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0001;
                    3: v = 32'hffff_ffff;
                    4: v = 32'h0000_0000;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_item(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
        in_item_t it;
        it.opcode = op;
        it.a_num  = an;
        it.a_den  = ad;
        it.b_num  = bn;
        it.b_den  = bd;
        pending_items.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // stimulus: directed corners, then random beats
    // ------------------------------------------------------------------
    initial
    begin
        queue_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        queue_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);           // zero numerator
        queue_item(OP_MUL, 32'd4, 32'd6, 32'd3, 32'd8);
        queue_item(OP_DIV, 32'd4, 32'd6, 32'd3, 32'd8);
        queue_item(OP_MUL, 32'd1, 32'd7, 32'd1, 32'd1);           // num +1, no reduce
        queue_item(OP_MUL, 32'd6, 32'd1, 32'd1, 32'd1);           // den +1
        queue_item(OP_MUL, -32'd1, 32'd3, 32'd1, 32'd1);          // num -1
        queue_item(OP_MUL, 32'd5, 32'd0, 32'd2, 32'd3);           // infinite
        queue_item(OP_MUL, 32'd0, 32'd0, 32'd2, 32'd3);           // 0/0 -> 0/1
        queue_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);           // divide by zero
        queue_item(OP_MUL, 32'd6, -32'd4, 32'd2, 32'd3);          // negative den kept
        queue_item(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1); // overflow
        queue_item(OP_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
        queue_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_item(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        queue_item(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        queue_item(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff);
        queue_item(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_item(OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        queue_item(OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_item(OP_DIV, 32'd12, 32'd35, -32'd9, 32'd14);
        for (int i = 0; i < N_RANDOM; i++)
            queue_item(2'($urandom_range(0, 3)), rand_field(), rand_field(),
                       rand_field(), rand_field());
    end

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            item       <= '0;
            push_gap   <= 0;
            push_burst <= 1'b0;
        end
        else if (!(push && full))
        begin
            if (push)
                expected_results.push_back(predict_fraction(item));
            if (push_gap > 0)
            begin
                push     <= 1'b0;
                push_gap <= push_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                push <= 1'b1;
                item <= pending_items.pop_front();
                if ($urandom_range(0, 19) == 0)
                    push_burst <= !push_burst;
                push_gap <= push_burst ? 0 : $urandom_range(0, 16);
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_res;
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_gap   <= 0;
            pop_burst <= 1'b0;
            err_cnt   <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat");
                    err_cnt <= err_cnt + 1;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result.res_num !== exp_res.res_num)
                        $error("res_num: expected %0d, got %0d",
                               exp_res.res_num, result.res_num);
                    if (result.res_den !== exp_res.res_den)
                        $error("res_den: expected %0d, got %0d",
                               exp_res.res_den, result.res_den);
                    if (result.kind !== exp_res.kind)
                        $error("kind: expected %0d, got %0d", exp_res.kind, result.kind);
                    if (result.is_integer !== exp_res.is_integer)
                        $error("is_integer: expected %0d, got %0d",
                               exp_res.is_integer, result.is_integer);
                    if (result.overflow !== exp_res.overflow)
                        $error("overflow: expected %0d, got %0d",
                               exp_res.overflow, result.overflow);
                    if (result !== exp_res)
                        err_cnt <= err_cnt + 1;
                end
            end
            // pop pacing: outside a burst, hold low for a drawn wait after each taken beat
            if (pop && !empty)
            begin
                if ($urandom_range(0, 19) == 0)
                    pop_burst <= !pop_burst;
                pop_gap <= pop_burst ? 0 : $urandom_range(0, 16);
                pop     <= pop_burst;
            end
            else if (pop_gap > 0)
            begin
                pop     <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // timeout
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYC_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        // sample at the falling edge so the clocked blocks have settled
        while (pending_items.size() > 0 || push || expected_results.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_cnt == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
